FILE: rtl/dvrt_pkg.sv
// shared types and constants of the distance-vector route table
package dvrt_pkg;

  localparam int NODES     = 64;
  localparam int ID_W      = 6;
  localparam int COST_W    = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [COST_W-1:0] COST_INF     = 16'hFFFF;
  localparam logic [COST_W-1:0] COST_SAT     = 16'hFFFE;
  localparam logic [TIME_W-1:0] LIFETIME_RST = 32'd45000;
  localparam logic [ID_W-1:0]   SCAN_LAST    = ID_W'(NODES - 1);

  typedef enum logic [1:0] {
    K_ADV  = 2'd0,
    K_MEAS = 2'd1,
    K_LOOK = 2'd2,
    K_TICK = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ID   = 1'b0,
    CFG_LIFETIME = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV_SUM,
    S_ADV_UPD,
    S_MEAS_UPD,
    S_LOOK,
    S_TICK_SCAN,
    S_TICK_DRAIN,
    S_TICK_END
  } state_t;

  typedef enum logic [1:0] {
    RD_IN_NB,
    RD_IN_DST,
    RD_DST,
    RD_SCAN
  } rd_sel_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [ID_W-1:0]   hop;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    logic    latch;
    rd_sel_t rd_sel;
    logic    sum_en;
    logic    adv_upd;
    logic    meas_upd;
    logic    look_out;
    logic    scan_issue;
    logic    tick_end;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

  typedef struct packed {
    logic              announce;
    logic [ID_W-1:0]   dest;
    logic [COST_W-1:0] cost;
    logic [ID_W-1:0]   hop;
    logic              found;
    logic              local_res;
    logic              batch_end;
    logic              last;
  } res_t;

endpackage

FILE: rtl/dvrt_ctrl.sv
// sequencing state machine of the route table
module dvrt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_kind,
  input  dvrt_pkg::dp_stat_t stat,
  output dvrt_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import dvrt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (kind_t'(in_kind))
            K_ADV:   state_nxt = S_ADV_SUM;
            K_MEAS:  state_nxt = S_MEAS_UPD;
            K_LOOK:  state_nxt = S_LOOK;
            K_TICK:  state_nxt = S_TICK_SCAN;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADV_SUM:    state_nxt = S_ADV_UPD;
      S_ADV_UPD:    state_nxt = S_IDLE;
      S_MEAS_UPD:   state_nxt = S_IDLE;
      S_LOOK:       state_nxt = S_IDLE;
      S_TICK_SCAN:  state_nxt = stat.scan_last ? S_TICK_DRAIN : S_TICK_SCAN;
      S_TICK_DRAIN: state_nxt = S_TICK_END;
      S_TICK_END:   state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_IN_NB;
    case (state_r)
      S_IDLE: begin
        cmd.latch  = start;
        // lookups read the destination entry first, everything else the neighbor
        cmd.rd_sel = (kind_t'(in_kind) == K_LOOK) ? RD_IN_DST : RD_IN_NB;
      end
      S_ADV_SUM: begin
        cmd.sum_en = 1'b1;
        cmd.rd_sel = RD_DST;
      end
      S_ADV_UPD:  cmd.adv_upd  = 1'b1;
      S_MEAS_UPD: cmd.meas_upd = 1'b1;
      S_LOOK:     cmd.look_out = 1'b1;
      S_TICK_SCAN: begin
        cmd.scan_issue = 1'b1;
        cmd.rd_sel     = RD_SCAN;
      end
      S_TICK_END: cmd.tick_end = 1'b1;
      default: cmd = '0;
    endcase
  end

  assign busy = (state_r != S_IDLE) || !rst_n;

endmodule

FILE: rtl/dvrt_dp.sv
// route table memory, valid bits, update arithmetic and result register
module dvrt_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dvrt_pkg::dp_cmd_t              cmd,
  output dvrt_pkg::dp_stat_t             stat,
  input  logic [dvrt_pkg::ID_W-1:0]      in_neighbor_id,
  input  logic [dvrt_pkg::ID_W-1:0]      in_dest_id,
  input  logic [dvrt_pkg::COST_W-1:0]    in_cost,
  input  logic [dvrt_pkg::TIME_W-1:0]    in_now,
  input  logic                           in_end_of_packet,
  input  logic                           cfg_wr_en,
  input  logic [dvrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dvrt_pkg::CFG_W-1:0]     cfg_data,
  output logic                           out_valid,
  output dvrt_pkg::res_t                 out_res
);
  import dvrt_pkg::*;

  // configuration
  logic [ID_W-1:0]   own_id_r;
  logic [TIME_W-1:0] lifetime_r;

  // latched transaction
  logic [ID_W-1:0]   nb_r;
  logic [ID_W-1:0]   dst_r;
  logic [COST_W-1:0] cost_r;
  logic [TIME_W-1:0] now_r;
  logic              eop_r;

  // table
  entry_t            mem [NODES];
  entry_t            rdata_r;
  logic [NODES-1:0]  valid_r;
  logic [ID_W-1:0]   rd_addr;
  logic              mem_we;
  logic [ID_W-1:0]   wr_addr;
  entry_t            wr_data;
  logic              v_set;
  logic              v_clr;
  logic [ID_W-1:0]   v_addr;

  // arithmetic
  logic [COST_W-1:0] sum_r;
  logic [COST_W:0]   sum_wide;
  logic [COST_W-1:0] sum_nxt;
  logic [COST_W-1:0] rtt;
  logic [TIME_W-1:0] exp_new;
  logic              known;
  logic              dst_valid;

  // expiry scan
  logic [ID_W-1:0]   scan_r;
  logic              chk_v_r;
  logic [ID_W-1:0]   chk_idx_r;
  logic              pend_v_r;
  logic [ID_W-1:0]   pend_idx_r;
  logic              exp_hit;

  // result
  logic              emit;
  res_t              res;
  logic              out_valid_r;
  res_t              out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r   <= '0;
      lifetime_r <= LIFETIME_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OWN_ID:   own_id_r   <= cfg_data[ID_W-1:0];
        CFG_LIFETIME: lifetime_r <= cfg_data[TIME_W-1:0];
        default:      own_id_r   <= own_id_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      nb_r   <= in_neighbor_id;
      dst_r  <= in_dest_id;
      cost_r <= in_cost;
      now_r  <= in_now;
      eop_r  <= in_end_of_packet;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_IN_NB:  rd_addr = in_neighbor_id;
      RD_IN_DST: rd_addr = in_dest_id;
      RD_DST:    rd_addr = dst_r;
      RD_SCAN:   rd_addr = scan_r;
      default:   rd_addr = in_neighbor_id;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (v_set) begin
      valid_r[v_addr] <= 1'b1;
    end else if (v_clr) begin
      valid_r[v_addr] <= 1'b0;
    end
  end

  // neighbor cost plus advertised cost, saturating below infinity
  assign sum_wide = {1'b0, rdata_r.cost} + {1'b0, cost_r};
  assign sum_nxt  = (sum_wide > {1'b0, COST_SAT}) ? COST_SAT : sum_wide[COST_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      sum_r <= sum_nxt;
    end
  end

  assign rtt       = (cost_r > COST_SAT) ? COST_SAT : cost_r;
  assign exp_new   = now_r + lifetime_r;
  assign known     = valid_r[nb_r];
  assign dst_valid = valid_r[dst_r];

  always_comb begin
    emit    = 1'b0;
    res     = '0;
    mem_we  = 1'b0;
    wr_addr = dst_r;
    wr_data = rdata_r;
    v_set   = 1'b0;
    v_clr   = 1'b0;
    v_addr  = dst_r;
    exp_hit = 1'b0;

    if (cmd.adv_upd) begin
      emit          = 1'b1;
      res.last      = 1'b1;
      res.batch_end = eop_r;
      res.found     = known;
      if (known && (dst_r != own_id_r)) begin
        if (!dst_valid) begin
          if (cost_r != COST_INF) begin
            mem_we       = 1'b1;
            wr_data      = '{cost: sum_r, hop: nb_r, expiry: exp_new};
            v_set        = 1'b1;
            res.announce = 1'b1;
            res.dest     = dst_r;
            res.cost     = sum_r;
            res.hop      = nb_r;
          end
        end else if (cost_r == COST_INF) begin
          // withdrawal only counts when it comes from the current hop
          if (rdata_r.hop == nb_r) begin
            v_clr        = 1'b1;
            res.announce = 1'b1;
            res.dest     = dst_r;
            res.cost     = COST_INF;
            res.hop      = rdata_r.hop;
          end
        end else begin
          mem_we         = 1'b1;
          wr_data.expiry = exp_new;
          if (rdata_r.hop == nb_r) begin
            if (rdata_r.cost != sum_r) begin
              wr_data.cost = sum_r;
              res.announce = 1'b1;
              res.dest     = dst_r;
              res.cost     = sum_r;
              res.hop      = nb_r;
            end
          end else if (rdata_r.cost > sum_r) begin
            wr_data.cost = sum_r;
            wr_data.hop  = nb_r;
            res.announce = 1'b1;
            res.dest     = dst_r;
            res.cost     = sum_r;
            res.hop      = nb_r;
          end
        end
      end
    end else if (cmd.meas_upd) begin
      emit          = 1'b1;
      res.last      = 1'b1;
      res.batch_end = 1'b1;
      res.found     = known;
      wr_addr       = nb_r;
      v_addr        = nb_r;
      if (!known) begin
        mem_we       = 1'b1;
        wr_data      = '{cost: rtt, hop: nb_r, expiry: exp_new};
        v_set        = 1'b1;
        res.announce = 1'b1;
        res.dest     = nb_r;
        res.cost     = rtt;
        res.hop      = nb_r;
      end else begin
        mem_we         = 1'b1;
        wr_data.expiry = exp_new;
        if (rdata_r.hop == nb_r) begin
          if (rdata_r.cost != rtt) begin
            wr_data.cost = rtt;
            res.announce = 1'b1;
            res.dest     = nb_r;
            res.cost     = rtt;
            res.hop      = nb_r;
          end
        end else if (rdata_r.cost > rtt) begin
          wr_data.cost = rtt;
          wr_data.hop  = nb_r;
          res.announce = 1'b1;
          res.dest     = nb_r;
          res.cost     = rtt;
          res.hop      = nb_r;
        end
      end
    end else if (cmd.look_out) begin
      emit     = 1'b1;
      res.last = 1'b1;
      res.dest = dst_r;
      if (dst_r == own_id_r) begin
        res.local_res = 1'b1;
      end else if (dst_valid) begin
        res.found = 1'b1;
        res.cost  = rdata_r.cost;
        res.hop   = rdata_r.hop;
      end else begin
        res.cost = COST_INF;
      end
    end else if (cmd.tick_end) begin
      emit          = 1'b1;
      res.last      = 1'b1;
      res.batch_end = 1'b1;
      if (pend_v_r) begin
        res.announce = 1'b1;
        res.dest     = pend_idx_r;
        res.cost     = COST_INF;
        res.hop      = pend_idx_r;
      end
    end else if (chk_v_r && valid_r[chk_idx_r] && (rdata_r.expiry < now_r)) begin
      // one expired entry is held back so the final one can carry last
      exp_hit = 1'b1;
      v_clr   = 1'b1;
      v_addr  = chk_idx_r;
      if (pend_v_r) begin
        emit         = 1'b1;
        res.announce = 1'b1;
        res.dest     = pend_idx_r;
        res.cost     = COST_INF;
        res.hop      = pend_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r   <= '0;
      chk_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      chk_v_r <= cmd.scan_issue;
      if (cmd.scan_issue) begin
        scan_r <= scan_r + 1'b1;
      end
      if (exp_hit) begin
        pend_v_r <= 1'b1;
      end else if (cmd.tick_end) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      chk_idx_r <= scan_r;
    end
    if (exp_hit) begin
      pend_idx_r <= chk_idx_r;
    end
  end

  assign stat.scan_last = (scan_r == SCAN_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: rtl/distance_vector_route_table.sv
// Distance-vector route table: an accepted lookup or neighbor measurement is handled in S_LOOK or
// S_MEAS_UPD, an advertised entry in S_ADV_SUM and then S_ADV_UPD; the result is registered. Busy
// stays high until the block is back in S_IDLE, and a new transaction is only taken in S_IDLE.
// An expiry tick walks all 64 entries through the single read port of the table memory, one
// entry per cycle, then S_TICK_DRAIN and S_TICK_END; announcements stream out as expired routes
// are found. Synchronous reset invalidates every route at once (per-entry valid flops), own_id
// to 0, entry_lifetime to 45000; no clearing pass. Results cannot be stalled by the receiver.
module distance_vector_route_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_kind,
  input  logic [dvrt_pkg::ID_W-1:0]      in_neighbor_id,
  input  logic [dvrt_pkg::ID_W-1:0]      in_dest_id,
  input  logic [dvrt_pkg::COST_W-1:0]    in_cost,
  input  logic [dvrt_pkg::TIME_W-1:0]    in_now,
  input  logic                           in_end_of_packet,
  output logic                           out_valid,
  output logic                           out_announce,
  output logic [dvrt_pkg::ID_W-1:0]      out_route_dest,
  output logic [dvrt_pkg::COST_W-1:0]    out_route_cost,
  output logic [dvrt_pkg::ID_W-1:0]      out_route_hop,
  output logic                           out_found,
  output logic                           out_local_res,
  output logic                           out_batch_end,
  output logic                           out_last,
  input  logic                           cfg_wr_en,
  input  logic [dvrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dvrt_pkg::CFG_W-1:0]     cfg_data
);
  import dvrt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  res_t     res;

  dvrt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  dvrt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_neighbor_id   (in_neighbor_id),
    .in_dest_id       (in_dest_id),
    .in_cost          (in_cost),
    .in_now           (in_now),
    .in_end_of_packet (in_end_of_packet),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_res          (res)
  );

  assign out_announce   = res.announce;
  assign out_route_dest = res.dest;
  assign out_route_cost = res.cost;
  assign out_route_hop  = res.hop;
  assign out_found      = res.found;
  assign out_local_res  = res.local_res;
  assign out_batch_end  = res.batch_end;
  assign out_last       = res.last;

endmodule

FILE: rtl/dvrt_chk.sv
// port-level checks of the route table, bound to the top level
module dvrt_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic                        out_announce,
  input logic [dvrt_pkg::COST_W-1:0] out_route_cost,
  input logic                        out_found,
  input logic                        out_local_res,
  input logic                        out_last
);
  import dvrt_pkg::*;

  // an accepted transaction always occupies the block for at least one cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // only announcements can precede the final result of a transaction
  a_nonlast_announce: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_announce)
    else $error("non-final result is not an announcement");

  // a local lookup reports no route
  a_local_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_local_res |-> !out_found && !out_announce && (out_route_cost == '0))
    else $error("local lookup result carries a route");

  // reset leaves nothing in flight
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind distance_vector_route_table dvrt_chk u_dvrt_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_announce   (out_announce),
  .out_route_cost (out_route_cost),
  .out_found      (out_found),
  .out_local_res  (out_local_res),
  .out_last       (out_last)
);
